### rtl/mbc_pkg.sv
package mbc_pkg;

   localparam int MAX_WIDTH_DEFAULT      = 1024;
   localparam int COEF_FRAC_BITS_DEFAULT = 12;
   localparam int FIFO_DEPTH             = 16;

   localparam logic [2:0] REG_IMAGE_WIDTH     = 3'd0;
   localparam logic [2:0] REG_IMAGE_HEIGHT    = 3'd1;
   localparam logic [2:0] REG_COEF_ROW_TOP    = 3'd2;
   localparam logic [2:0] REG_COEF_ROW_MID    = 3'd3;
   localparam logic [2:0] REG_COEF_ROW_BOTTOM = 3'd4;

   localparam logic [10:0] IMAGE_WIDTH_RESET     = 11'd512;
   localparam logic [10:0] IMAGE_HEIGHT_RESET    = 11'd512;
   localparam logic [47:0] COEF_ROW_TOP_RESET    = 48'h0000_1000_0000;
   localparam logic [47:0] COEF_ROW_MID_RESET    = 48'h1000_C000_1000;
   localparam logic [47:0] COEF_ROW_BOTTOM_RESET = 48'h0000_1000_0000;

   typedef logic [2:0][2:0][7:0] mbc_window_type;

   typedef struct packed {
      logic emit_left;
      logic emit_end;
      logic lc_two;
      logic tr_two;
      logic last_row;
   } mbc_ctrl_type;

   typedef struct packed {
      logic [7:0] pixel;
      logic       end_of_row;
      logic       end_of_frame;
   } mbc_result_type;

endpackage

### rtl/mbc_kernel.sv
module mbc_kernel #(
   parameter int COEF_FRAC_BITS = mbc_pkg::COEF_FRAC_BITS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   input  mbc_pkg::mbc_ctrl_type         in_ctrl,
   input  mbc_pkg::mbc_window_type       window,
   input  logic [47:0]                   coef_top,
   input  logic [47:0]                   coef_mid,
   input  logic [47:0]                   coef_bottom,
   output logic [1:0]                    out_count,
   output mbc_pkg::mbc_result_type [1:0] out_result
);

   localparam int PW = 25;
   localparam int RW = 27;
   localparam int TW = 29;

   logic signed [PW-1:0] prod_in  [2][3][3];
   logic signed [PW-1:0] prod_ff  [2][3][3];
   logic signed [RW-1:0] rsum_in  [2][3];
   logic signed [RW-1:0] rsum_ff  [2][3];
   logic signed [TW-1:0] total_in [2];
   logic signed [TW-1:0] total_ff [2];

   logic                  p_valid_ff, r_valid_ff, t_valid_ff;
   mbc_pkg::mbc_ctrl_type p_ctrl_ff, r_ctrl_ff, t_ctrl_ff;

   logic [7:0]            pix [2];
   mbc_pkg::mbc_result_type res_left, res_end;

   always_comb begin
      int rsel;
      int csel;
      logic [47:0] crow;
      logic [7:0]  tap;
      for (int s = 0; s < 2; s++) begin
         for (int r = 0; r < 3; r++) begin
            for (int k = 0; k < 3; k++) begin
               rsel = (r == 0) ? (in_ctrl.tr_two ? 2 : 0) : r;
               if (s == 0) begin
                  csel = (k == 0) ? (in_ctrl.lc_two ? 2 : 0) : k;
               end else begin
                  csel = (k == 1) ? 2 : 1;
               end
               crow = (r == 0) ? coef_top : ((r == 1) ? coef_mid : coef_bottom);
               tap  = window[rsel][csel];
               prod_in[s][r][k] = PW'($signed({1'b0, tap}) * $signed(crow[16*k +: 16]));
            end
         end
      end
   end

   always_comb begin
      for (int s = 0; s < 2; s++) begin
         for (int r = 0; r < 3; r++) begin
            rsum_in[s][r] = RW'(prod_ff[s][r][0]) + RW'(prod_ff[s][r][1])
                          + RW'(prod_ff[s][r][2]);
         end
         total_in[s] = TW'(rsum_ff[s][0]) + TW'(rsum_ff[s][1]) + TW'(rsum_ff[s][2]);
      end
   end

   always_ff @(posedge clock) begin
      prod_ff   <= prod_in;
      rsum_ff   <= rsum_in;
      total_ff  <= total_in;
      p_ctrl_ff <= in_ctrl;
      r_ctrl_ff <= p_ctrl_ff;
      t_ctrl_ff <= r_ctrl_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p_valid_ff <= 1'b0;
         r_valid_ff <= 1'b0;
         t_valid_ff <= 1'b0;
      end else begin
         p_valid_ff <= in_valid;
         r_valid_ff <= p_valid_ff;
         t_valid_ff <= r_valid_ff;
      end
   end

   always_comb begin
      logic [TW-2:0] q;
      for (int s = 0; s < 2; s++) begin
         q = total_ff[s][TW-2:0] >> COEF_FRAC_BITS;
         if (total_ff[s][TW-1] || (total_ff[s] == '0)) begin
            pix[s] = 8'd0;
         end else if (q > (TW-1)'(255)) begin
            pix[s] = 8'hFF;
         end else begin
            pix[s] = q[7:0];
         end
      end
   end

   always_comb begin
      res_left.pixel        = pix[0];
      res_left.end_of_row   = 1'b0;
      res_left.end_of_frame = 1'b0;
      res_end.pixel         = pix[1];
      res_end.end_of_row    = 1'b1;
      res_end.end_of_frame  = t_ctrl_ff.last_row;
      if (t_ctrl_ff.emit_left) begin
         out_result[0] = res_left;
      end else begin
         out_result[0] = res_end;
      end
      out_result[1] = res_end;
      if (t_valid_ff) begin
         out_count = {1'b0, t_ctrl_ff.emit_left} + {1'b0, t_ctrl_ff.emit_end};
      end else begin
         out_count = 2'd0;
      end
   end

endmodule

### rtl/mbc_fifo.sv
module mbc_fifo (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [1:0]                    push_count,
   input  mbc_pkg::mbc_result_type [1:0] push_data,
   input  logic                          pop,
   output logic                          out_valid,
   output mbc_pkg::mbc_result_type       out_data
);

   localparam int PTRW = $clog2(mbc_pkg::FIFO_DEPTH);
   localparam int CNTW = $clog2(mbc_pkg::FIFO_DEPTH + 1);

   mbc_pkg::mbc_result_type queue_mem [mbc_pkg::FIFO_DEPTH];
   mbc_pkg::mbc_result_type out_data_ff;

   logic [PTRW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTRW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNTW-1:0] count_ff, count_in;
   logic            out_valid_ff, out_valid_in;
   logic            load;

   always_ff @(posedge clock) begin
      if (push_count != 2'd0) begin
         queue_mem[wr_ptr_ff] <= push_data[0];
      end
      if (push_count == 2'd2) begin
         queue_mem[wr_ptr_ff + PTRW'(1)] <= push_data[1];
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         out_data_ff <= queue_mem[rd_ptr_ff];
      end
   end

   always_comb begin
      load      = (count_ff != '0) && (!out_valid_ff || pop);
      wr_ptr_in = wr_ptr_ff + PTRW'(push_count);
      rd_ptr_in = rd_ptr_ff + PTRW'(load);
      count_in  = count_ff + CNTW'(push_count) - CNTW'(load);
      if (load) begin
         out_valid_in = 1'b1;
      end else if (pop) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff    <= '0;
         rd_ptr_ff    <= '0;
         count_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         wr_ptr_ff    <= wr_ptr_in;
         rd_ptr_ff    <= rd_ptr_in;
         count_ff     <= count_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;

endmodule

### rtl/mirror_border_conv3x3.sv
// Channel  Dir  Ports     Word contents
// req      in   req_t*    tdata: pixel[7:0]; tuser: kind (1 = flush tick)
// rsp      out  rsp_t*    tdata: filtered_pixel[7:0]; tlast: end_of_row; tuser: end_of_frame
// csr      in   csr_*     APB, 64-bit data, register i at byte address 8*i
//
// One input word is taken per cycle while req_tready is high; the single line store is read when a word is
// taken for the frame and written back on the next cycle, so that port sets the rate.
// A result passes the line-store read, window, product, row-sum and total registers, then the queue.
// Results come out at most one per cycle through a 16-word queue; req_tready drops
// while the queue and the words in flight could fill it.
// Synchronous reset clears the counters and pipeline valids; the line store is not cleared.
module mirror_border_conv3x3 #(
   parameter int MAX_WIDTH      = mbc_pkg::MAX_WIDTH_DEFAULT,
   parameter int COEF_FRAC_BITS = mbc_pkg::COEF_FRAC_BITS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // pixel[7:0]
   input  logic        req_tuser,   // kind
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // filtered_pixel[7:0]
   output logic        rsp_tlast,
   output logic        rsp_tuser,   // end_of_frame
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [5:0]  csr_paddr,
   input  logic [63:0] csr_pwdata,
   output logic [63:0] csr_prdata,
   output logic        csr_pready
);

   localparam int AW   = $clog2(MAX_WIDTH);
   localparam int WW   = ($clog2(MAX_WIDTH + 1) > 11) ? $clog2(MAX_WIDTH + 1) : 11;
   localparam int PENW = $clog2(mbc_pkg::FIFO_DEPTH + 1);

   logic [10:0] image_width_ff, image_height_ff;
   logic [47:0] coef_top_ff, coef_mid_ff, coef_bottom_ff;
   logic        csr_write;
   logic [2:0]  csr_index;

   logic [AW-1:0] column_count_ff, column_count_in;
   logic [AW-1:0] flush_count_ff, flush_count_in;
   logic [10:0]   row_count_ff, row_count_in;
   logic [PENW-1:0] pending_ff, pending_in;

   logic [WW-1:0] w_cfg, w_eff;
   logic [10:0]   h_eff;
   logic [AW-1:0] cnt_sel, x, x_next;
   logic          row_end, take, emitting, accept, go, pop;
   logic [1:0]    n_results;
   mbc_pkg::mbc_ctrl_type ctrl;

   logic [15:0]   line_mem [MAX_WIDTH];
   logic [15:0]   rd_ff;

   logic                  s1_valid_ff, s2_valid_ff;
   mbc_pkg::mbc_ctrl_type s1_ctrl_ff, s2_ctrl_ff;
   logic                  s1_flush_ff;
   logic [7:0]            s1_pixel_ff;
   logic [AW-1:0]         s1_addr_ff;

   mbc_pkg::mbc_window_type window_ff, window_in;
   logic [7:0]              col_new [3];

   logic [1:0]                    push_count;
   mbc_pkg::mbc_result_type [1:0] push_data;
   mbc_pkg::mbc_result_type       head;

   assign csr_pready = 1'b1;
   assign csr_index  = csr_paddr[5:3];
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff  <= mbc_pkg::IMAGE_WIDTH_RESET;
         image_height_ff <= mbc_pkg::IMAGE_HEIGHT_RESET;
         coef_top_ff     <= mbc_pkg::COEF_ROW_TOP_RESET;
         coef_mid_ff     <= mbc_pkg::COEF_ROW_MID_RESET;
         coef_bottom_ff  <= mbc_pkg::COEF_ROW_BOTTOM_RESET;
      end else if (csr_write) begin
         case (csr_index)
            mbc_pkg::REG_IMAGE_WIDTH:     image_width_ff  <= csr_pwdata[10:0];
            mbc_pkg::REG_IMAGE_HEIGHT:    image_height_ff <= csr_pwdata[10:0];
            mbc_pkg::REG_COEF_ROW_TOP:    coef_top_ff     <= csr_pwdata[47:0];
            mbc_pkg::REG_COEF_ROW_MID:    coef_mid_ff     <= csr_pwdata[47:0];
            mbc_pkg::REG_COEF_ROW_BOTTOM: coef_bottom_ff  <= csr_pwdata[47:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         mbc_pkg::REG_IMAGE_WIDTH:     csr_prdata = {53'd0, image_width_ff};
         mbc_pkg::REG_IMAGE_HEIGHT:    csr_prdata = {53'd0, image_height_ff};
         mbc_pkg::REG_COEF_ROW_TOP:    csr_prdata = {16'd0, coef_top_ff};
         mbc_pkg::REG_COEF_ROW_MID:    csr_prdata = {16'd0, coef_mid_ff};
         mbc_pkg::REG_COEF_ROW_BOTTOM: csr_prdata = {16'd0, coef_bottom_ff};
         default:                      csr_prdata = 64'd0;
      endcase
   end

   always_comb begin
      w_cfg = WW'(image_width_ff);
      if (w_cfg < WW'(2)) begin
         w_eff = WW'(2);
      end else if (w_cfg > WW'(MAX_WIDTH)) begin
         w_eff = WW'(MAX_WIDTH);
      end else begin
         w_eff = w_cfg;
      end
      h_eff   = (image_height_ff < 11'd2) ? 11'd2 : image_height_ff;
      cnt_sel = req_tuser ? flush_count_ff : column_count_ff;
      x       = (WW'(cnt_sel) >= w_eff) ? AW'(w_eff - WW'(1)) : cnt_sel;
      x_next  = x + AW'(1);
      row_end = (WW'(x) + WW'(1)) >= w_eff;
      take    = req_tuser ? (row_count_ff >= h_eff) : (row_count_ff < h_eff);
      emitting       = req_tuser || (row_count_ff != 11'd0);
      ctrl.emit_left = emitting && (x != '0);
      ctrl.emit_end  = emitting && row_end;
      ctrl.lc_two    = (x == AW'(1));
      ctrl.tr_two    = !req_tuser && (row_count_ff == 11'd1);
      ctrl.last_row  = req_tuser;
      n_results      = {1'b0, ctrl.emit_left} + {1'b0, ctrl.emit_end};
   end

   assign req_tready = (pending_ff <= PENW'(mbc_pkg::FIFO_DEPTH - 2));
   assign accept     = req_tvalid && req_tready;
   assign go         = accept && take;
   assign pop        = rsp_tvalid && rsp_tready;

   always_comb begin
      column_count_in = column_count_ff;
      flush_count_in  = flush_count_ff;
      row_count_in    = row_count_ff;
      if (go) begin
         if (!req_tuser) begin
            if (row_end) begin
               column_count_in = '0;
               row_count_in    = row_count_ff + 11'd1;
            end else begin
               column_count_in = x_next;
            end
         end else begin
            if (row_end) begin
               flush_count_in  = '0;
               row_count_in    = 11'd0;
               column_count_in = '0;
            end else begin
               flush_count_in = x_next;
            end
         end
      end
      pending_in = pending_ff + (go ? PENW'(n_results) : PENW'(0)) - PENW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_count_ff <= '0;
         flush_count_ff  <= '0;
         row_count_ff    <= '0;
         pending_ff      <= '0;
         s1_valid_ff     <= 1'b0;
         s2_valid_ff     <= 1'b0;
      end else begin
         column_count_ff <= column_count_in;
         flush_count_ff  <= flush_count_in;
         row_count_ff    <= row_count_in;
         pending_ff      <= pending_in;
         s1_valid_ff     <= go;
         s2_valid_ff     <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (go) begin
         rd_ff <= line_mem[x];
      end
   end

   always_ff @(posedge clock) begin
      if (s1_valid_ff && !s1_flush_ff) begin
         line_mem[s1_addr_ff] <= {rd_ff[7:0], s1_pixel_ff};
      end
   end

   always_ff @(posedge clock) begin
      s1_ctrl_ff  <= ctrl;
      s1_flush_ff <= req_tuser;
      s1_pixel_ff <= req_tdata;
      s1_addr_ff  <= x;
      s2_ctrl_ff  <= s1_ctrl_ff;
   end

   always_comb begin
      col_new[0] = rd_ff[15:8];
      col_new[1] = rd_ff[7:0];
      col_new[2] = s1_flush_ff ? rd_ff[15:8] : s1_pixel_ff;
      for (int r = 0; r < 3; r++) begin
         window_in[r][0] = window_ff[r][1];
         window_in[r][1] = window_ff[r][2];
         window_in[r][2] = col_new[r];
      end
   end

   always_ff @(posedge clock) begin
      if (s1_valid_ff) begin
         window_ff <= window_in;
      end
   end

   mbc_kernel #(
      .COEF_FRAC_BITS(COEF_FRAC_BITS)
   ) u_kernel (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (s2_valid_ff),
      .in_ctrl     (s2_ctrl_ff),
      .window      (window_ff),
      .coef_top    (coef_top_ff),
      .coef_mid    (coef_mid_ff),
      .coef_bottom (coef_bottom_ff),
      .out_count   (push_count),
      .out_result  (push_data)
   );

   mbc_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_count (push_count),
      .push_data  (push_data),
      .pop        (pop),
      .out_valid  (rsp_tvalid),
      .out_data   (head)
   );

   assign rsp_tdata = head.pixel;
   assign rsp_tlast = head.end_of_row;
   assign rsp_tuser = head.end_of_frame;

endmodule

### tb/sv/mbc_filter_checker.sv
`timescale 1ns / 1ps

module mbc_filter_checker
   import mbc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [7:0]  req_tdata,   // pixel[7:0]
   input  logic        req_tuser,   // kind
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [7:0]  rsp_tdata,   // filtered_pixel[7:0]
   input  logic        rsp_tlast,
   input  logic        rsp_tuser,   // end_of_frame
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic        csr_pready,
   input  logic [5:0]  csr_paddr,
   input  logic [63:0] csr_pwdata,
   output int          mismatch_count,
   output int          pending_words
);

   logic [10:0]    width_reg;
   logic [10:0]    height_reg;
   logic [47:0]    coef_reg [3];
   logic [7:0]     upper_line [MAX_WIDTH_DEFAULT];
   logic [7:0]     lower_line [MAX_WIDTH_DEFAULT];
   logic [7:0]     win [3][3];
   int unsigned    col_cnt;
   int unsigned    row_cnt;
   int unsigned    flush_cnt;
   mbc_result_type expected_pixels [$];
   int             failures = 0;

   function automatic int unsigned used_width();
      if (width_reg < 11'd2) return 2;
      if (width_reg > MAX_WIDTH_DEFAULT) return MAX_WIDTH_DEFAULT;
      return 32'(width_reg);
   endfunction

   function automatic int unsigned used_height();
      return (height_reg < 11'd2) ? 2 : 32'(height_reg);
   endfunction

   task automatic restore_defaults();
      int i;
      int j;
      width_reg  = IMAGE_WIDTH_RESET;
      height_reg = IMAGE_HEIGHT_RESET;
      coef_reg[0] = COEF_ROW_TOP_RESET;
      coef_reg[1] = COEF_ROW_MID_RESET;
      coef_reg[2] = COEF_ROW_BOTTOM_RESET;
      for (i = 0; i < MAX_WIDTH_DEFAULT; i++) begin
         upper_line[i] = 8'd0;
         lower_line[i] = 8'd0;
      end
      for (i = 0; i < 3; i++) begin
         for (j = 0; j < 3; j++) begin
            win[i][j] = 8'd0;
         end
      end
      col_cnt   = 0;
      row_cnt   = 0;
      flush_cnt = 0;
      expected_pixels.delete();
   endtask

   task automatic write_reg(input logic [2:0] idx, input logic [63:0] data);
      case (idx)
         REG_IMAGE_WIDTH:     width_reg  = data[10:0];
         REG_IMAGE_HEIGHT:    height_reg = data[10:0];
         REG_COEF_ROW_TOP:    coef_reg[0] = data[47:0];
         REG_COEF_ROW_MID:    coef_reg[1] = data[47:0];
         REG_COEF_ROW_BOTTOM: coef_reg[2] = data[47:0];
         default: ;
      endcase
   endtask

   task automatic shift_in(input logic [7:0] a, input logic [7:0] b, input logic [7:0] c);
      int r;
      logic [7:0] col [3];
      col = '{a, b, c};
      for (r = 0; r < 3; r++) begin
         win[r][0] = win[r][1];
         win[r][1] = win[r][2];
         win[r][2] = col[r];
      end
   endtask

   function automatic logic [7:0] weigh_window(input int unsigned lc, input int unsigned cc,
                                               input int unsigned rc, input int unsigned tr);
      int unsigned        rows [3];
      int unsigned        cols [3];
      int                 r;
      int                 k;
      logic signed [15:0] c;
      longint             acc;
      longint             q;
      rows = '{tr, 1, 2};
      cols = '{lc, cc, rc};
      acc = 0;
      for (r = 0; r < 3; r++) begin
         for (k = 0; k < 3; k++) begin
            c = coef_reg[r][16*k +: 16];
            acc += longint'(c) * longint'(win[rows[r]][cols[k]]);
         end
      end
      if (acc < 0) q = -((-acc) >> COEF_FRAC_BITS_DEFAULT);
      else q = acc >> COEF_FRAC_BITS_DEFAULT;
      if (q < 0) q = 0;
      if (q > 255) q = 255;
      return q[7:0];
   endfunction

   task automatic emit_results(input int unsigned x, input int unsigned w,
                               input int unsigned tr, input bit last_row);
      mbc_result_type res;
      if (x >= 1) begin
         res.pixel        = weigh_window((x == 1) ? 2 : 0, 1, 2, tr);
         res.end_of_row   = 1'b0;
         res.end_of_frame = 1'b0;
         expected_pixels.push_back(res);
      end
      if (x + 1 >= w) begin
         res.pixel        = weigh_window(1, 2, 1, tr);
         res.end_of_row   = 1'b1;
         res.end_of_frame = last_row;
         expected_pixels.push_back(res);
      end
   endtask

   // Pixels beyond the last row and flush ticks inside the frame change nothing.
   task automatic take_word(input bit flush, input logic [7:0] px);
      int unsigned w;
      int unsigned h;
      int unsigned x;
      logic [7:0]  up;
      logic [7:0]  lo;
      w = used_width();
      h = used_height();
      if (!flush) begin
         if (row_cnt >= h) return;
         x = (col_cnt >= w) ? w - 1 : col_cnt;
         up = upper_line[x];
         lo = lower_line[x];
         upper_line[x] = lo;
         lower_line[x] = px;
         shift_in(up, lo, px);
         if (row_cnt >= 1) emit_results(x, w, (row_cnt == 1) ? 2 : 0, 1'b0);
         if (x + 1 >= w) begin
            col_cnt = 0;
            row_cnt++;
         end else begin
            col_cnt = x + 1;
         end
      end else begin
         if (row_cnt < h) return;
         x = (flush_cnt >= w) ? w - 1 : flush_cnt;
         up = upper_line[x];
         lo = lower_line[x];
         shift_in(up, lo, up);
         emit_results(x, w, 0, 1'b1);
         if (x + 1 >= w) begin
            flush_cnt = 0;
            row_cnt   = 0;
            col_cnt   = 0;
         end else begin
            flush_cnt = x + 1;
         end
      end
   endtask

   task automatic report_mismatch(input string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      failures++;
   endtask

   task automatic check_word();
      mbc_result_type want;
      if (expected_pixels.size() == 0) begin
         report_mismatch($sformatf("result word %0d with nothing expected", rsp_tdata));
      end else begin
         want = expected_pixels.pop_front();
         if (rsp_tdata !== want.pixel)
            report_mismatch($sformatf("filtered_pixel %0d, expected %0d", rsp_tdata, want.pixel));
         if (rsp_tlast !== want.end_of_row)
            report_mismatch($sformatf("end_of_row %0b, expected %0b", rsp_tlast,
                                      want.end_of_row));
         if (rsp_tuser !== want.end_of_frame)
            report_mismatch($sformatf("end_of_frame %0b, expected %0b", rsp_tuser,
                                      want.end_of_frame));
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         restore_defaults();
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready)
            write_reg(csr_paddr[5:3], csr_pwdata);
         if (req_tvalid && req_tready) take_word(req_tuser, req_tdata);
         if (rsp_tvalid && rsp_tready) check_word();
      end
      mismatch_count <= failures;
      pending_words  <= expected_pixels.size();
   end

endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
   import mbc_pkg::*;

   localparam int CYCLE_LIMIT = 1_000_000;

   typedef enum int {RX_STEADY, RX_HALF, RX_SPARSE, RX_MOSTLY} rx_mode_type;

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        req_tvalid  = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata   = 8'd0;   // pixel[7:0]
   logic        req_tuser   = 1'b0;   // kind
   logic        rsp_tvalid;
   logic        rsp_tready  = 1'b0;
   logic [7:0]  rsp_tdata;            // filtered_pixel[7:0]
   logic        rsp_tlast;
   logic        rsp_tuser;            // end_of_frame
   logic        csr_psel    = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite  = 1'b0;
   logic [5:0]  csr_paddr   = 6'd0;
   logic [63:0] csr_pwdata  = 64'd0;
   logic [63:0] csr_prdata;
   logic        csr_pready;

   int          mismatch_count;
   int          pending_words;
   int          burst_left   = 0;
   bit          hold_pending = 1'b0;
   int          hold_left    = 0;
   int          mode_left    = 0;
   rx_mode_type rx_mode      = RX_STEADY;
   int          cycles       = 0;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   mirror_border_conv3x3 u_top (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   mbc_filter_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tlast      (rsp_tlast),
      .rsp_tuser      (rsp_tuser),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_pready     (csr_pready),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .mismatch_count (mismatch_count),
      .pending_words  (pending_words)
   );

   initial begin
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("Regression FAIL");
      $finish;
   end

   // The receiver switches between stall patterns and honors one long hold-off.
   initial begin
      forever begin
         @(posedge clock);
         if (hold_pending) begin
            hold_pending = 1'b0;
            hold_left    = 400;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            if (mode_left == 0) begin
               rx_mode   = rx_mode_type'($urandom_range(0, 3));
               mode_left = $urandom_range(10, 300);
            end
            mode_left--;
            case (rx_mode)
               RX_STEADY: rsp_tready <= 1'b1;
               RX_HALF:   rsp_tready <= 1'($urandom_range(0, 1));
               RX_SPARSE: rsp_tready <= ($urandom_range(0, 3) == 0);
               default:   rsp_tready <= ($urandom_range(0, 7) != 0);
            endcase
         end
      end
   end

   function automatic int frame_cols(input logic [10:0] wreg);
      if (wreg < 11'd2) return 2;
      if (wreg > MAX_WIDTH_DEFAULT) return MAX_WIDTH_DEFAULT;
      return int'(wreg);
   endfunction

   function automatic int frame_rows(input logic [10:0] hreg);
      return (hreg < 11'd2) ? 2 : int'(hreg);
   endfunction

   function automatic logic [7:0] random_pixel();
      if ($urandom_range(0, 7) == 0) return $urandom_range(0, 1) ? 8'hFF : 8'h00;
      return 8'($urandom_range(0, 255));
   endfunction

   function automatic logic [47:0] random_coef_row();
      logic [47:0] row;
      int          k;
      for (k = 0; k < 3; k++) begin
         case ($urandom_range(0, 7))
            0:       row[16*k +: 16] = 16'h0000;
            1:       row[16*k +: 16] = 16'hFFFF;
            2:       row[16*k +: 16] = 16'h7FFF;
            3:       row[16*k +: 16] = 16'h8000;
            4:       row[16*k +: 16] = 16'($urandom);
            default: row[16*k +: 16] = 16'($urandom_range(0, 16'h3000)) - 16'h1800;
         endcase
      end
      return row;
   endfunction

   task automatic send_word(input bit flush, input logic [7:0] px);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                  : $urandom_range(1, 32);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= flush;
      req_tdata  <= px;
      do @(posedge clock); while (!req_tready);
      burst_left--;
   endtask

   task automatic wait_idle(input int settle);
      req_tvalid <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (pending_words != 0) @(posedge clock);
      repeat (settle) @(posedge clock);
   endtask

   task automatic csr_write(input logic [2:0] idx, input logic [63:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 3'b000};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic send_frame(input logic [10:0] wreg, input logic [10:0] hreg, input bit noisy);
      int cols;
      int rows;
      int i;
      cols = frame_cols(wreg);
      rows = frame_rows(hreg);
      for (i = 0; i < cols * rows; i++) begin
         if (noisy && $urandom_range(0, 19) == 0) send_word(1'b1, random_pixel());
         send_word(1'b0, random_pixel());
      end
      for (i = 0; i < cols; i++) begin
         if (noisy && $urandom_range(0, 9) == 0) send_word(1'b0, random_pixel());
         send_word(1'b1, random_pixel());
      end
   endtask

   initial begin
      int          random_words;
      logic [10:0] wreg;
      logic [10:0] hreg;
      random_words = 0;
      wreg = 11'd2;
      hreg = 11'd2;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      csr_write(REG_IMAGE_WIDTH, 64'd3);
      csr_write(REG_IMAGE_HEIGHT, 64'd2);
      send_word(1'b1, 8'hFF);
      send_word(1'b0, 8'h00);
      send_word(1'b0, 8'hFF);
      send_word(1'b0, 8'h00);
      send_word(1'b0, 8'hFF);
      send_word(1'b0, 8'h00);
      send_word(1'b0, 8'hFF);
      send_word(1'b0, 8'hAA);
      send_word(1'b1, 8'h55);
      send_word(1'b1, 8'h00);
      send_word(1'b1, 8'hFF);

      wait_idle(16);
      csr_write(REG_IMAGE_WIDTH, 64'd0);
      csr_write(REG_IMAGE_HEIGHT, 64'd1);
      csr_write(REG_COEF_ROW_TOP, 64'h0000_7FFF_0000);
      csr_write(REG_COEF_ROW_MID, 64'h8000_0800_FFFF);
      csr_write(REG_COEF_ROW_BOTTOM, 64'hFFFF_FFFF_FFFF);
      send_word(1'b0, 8'hFF);
      send_word(1'b0, 8'h01);
      send_word(1'b0, 8'h80);
      send_word(1'b0, 8'hFE);
      send_word(1'b1, 8'h7F);
      send_word(1'b1, 8'h80);

      wait_idle(16);
      csr_write(REG_IMAGE_WIDTH, 64'd48);
      csr_write(REG_IMAGE_HEIGHT, 64'd4);
      csr_write(REG_COEF_ROW_TOP, 64'(COEF_ROW_TOP_RESET));
      csr_write(REG_COEF_ROW_MID, 64'(COEF_ROW_MID_RESET));
      csr_write(REG_COEF_ROW_BOTTOM, 64'(COEF_ROW_BOTTOM_RESET));
      hold_pending = 1'b1;
      send_frame(11'd48, 11'd4, 1'b0);

      while (random_words < 800) begin
         if (random_words == 0 || $urandom_range(0, 2) != 0) begin
            wait_idle(16);
            case ($urandom_range(0, 9))
               0:       wreg = 11'($urandom_range(0, 1));
               1:       wreg = 11'($urandom_range(60, 130));
               default: wreg = 11'($urandom_range(2, 12));
            endcase
            hreg = ($urandom_range(0, 4) == 0) ? 11'($urandom_range(0, 1))
                                               : 11'($urandom_range(2, 6));
            csr_write(REG_IMAGE_WIDTH, 64'(wreg));
            csr_write(REG_IMAGE_HEIGHT, 64'(hreg));
            if ($urandom_range(0, 1)) csr_write(REG_COEF_ROW_TOP, 64'(random_coef_row()));
            if ($urandom_range(0, 1)) csr_write(REG_COEF_ROW_MID, 64'(random_coef_row()));
            if ($urandom_range(0, 1)) csr_write(REG_COEF_ROW_BOTTOM, 64'(random_coef_row()));
         end
         send_frame(wreg, hreg, 1'b1);
         random_words += frame_cols(wreg) * (frame_rows(hreg) + 1);
      end

      wait_idle(64);
      if (mismatch_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

### sim.f
rtl/mbc_pkg.sv
rtl/mbc_kernel.sv
rtl/mbc_fifo.sv
rtl/mirror_border_conv3x3.sv
tb/sv/mbc_filter_checker.sv
tb/sv/tb_top.sv
